[design/gwm_pkg.sv]
// Shared types, codes and byte compare for the wildcard glob matcher.
package gwm_pkg;

  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_QUEST  = 8'd63;
  localparam logic [7:0] UPPER_LO  = 8'd65;
  localparam logic [7:0] UPPER_HI  = 8'd90;
  localparam logic [7:0] LOWER_LO  = 8'd97;
  localparam logic [7:0] LOWER_HI  = 8'd122;
  localparam logic [7:0] CASE_DIFF = 8'd32;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_TEXT   = 2'd2,
    FN_END    = 2'd3
  } gwm_func_t;

  // broadcast to every cell for the transaction at hand
  typedef struct packed {
    logic      take;
    gwm_func_t func;
    logic [7:0] byte_value;
    logic      fold;
    logic      started;
  } gwm_ctl_t;

  // handed from one cell to the next in the same cycle
  typedef struct packed {
    logic cur_close;
    logic advance;
    logic next_close;
  } gwm_link_t;

  function automatic logic gwm_byte_match(input logic [7:0] p, input logic [7:0] t,
                                          input logic fold);
    logic hit;
    hit = (p == t) || (p == CH_QUEST);
    if (fold) begin
      if (p >= UPPER_LO && p <= UPPER_HI && (p + CASE_DIFF) == t) hit = 1'b1;
      if (p >= LOWER_LO && p <= LOWER_HI && (p - CASE_DIFF) == t) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

[design/gwm_ifs.sv]
// Channel interfaces: input items, results and the configuration write.
interface gwm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] byte_value;
  modport source (output valid, output func, output byte_value, input ready);
  modport sink (input valid, input func, input byte_value, output ready);
endinterface

interface gwm_out_if;
  logic valid;
  logic ready;
  logic match;
  logic pattern_overflow;
  modport source (output valid, output match, output pattern_overflow, input ready);
  modport sink (input valid, input match, input pattern_overflow, output ready);
endinterface

interface gwm_cfg_if;
  logic valid;
  logic ready;
  logic case_insensitive;
  modport source (output valid, output case_insensitive, input ready);
  modport sink (input valid, input case_insensitive, output ready);
endinterface

[design/gwm_cell.sv]
// One pattern position: stored byte, fill bit and active bit.
module gwm_cell
  import gwm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  gwm_ctl_t  ctl,
  input  logic      seed,
  input  logic      prev_valid,
  input  gwm_link_t link_in,
  output gwm_link_t link_out,
  output logic      valid_out,
  output logic      hit
);

  logic       valid_r;
  logic       active_r;
  logic [7:0] byte_r;
  logic       star;
  logic       cur;
  logic       nxt;

  always_comb begin
    star = valid_r && (byte_r == CH_STAR);
    // a fresh text starts with only position zero active
    cur  = (ctl.started ? active_r : seed) | link_in.cur_close;
    nxt  = (cur & star) | link_in.advance | link_in.next_close;
    link_out.cur_close  = cur & star;
    link_out.advance    = cur & valid_r & !star &
                          gwm_byte_match(byte_r, ctl.byte_value, ctl.fold);
    link_out.next_close = nxt & star;
    hit       = cur & prev_valid & !valid_r;
    valid_out = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      active_r <= 1'b0;
    end else if (ctl.take) begin
      case (ctl.func)
        FN_CLEAR:  valid_r  <= 1'b0;
        FN_APPEND: valid_r  <= valid_r | prev_valid;
        FN_TEXT:   active_r <= nxt;
        default:   active_r <= active_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && ctl.func == FN_APPEND && prev_valid && !valid_r) begin
      byte_r <= ctl.byte_value;
    end
  end

endmodule

[design/wildcard_glob_matcher.sv]
// Top level of the wildcard glob matcher: cell row, control and result register.
// Usage:
//   in_chan carries func and byte_value. func 0 clears the pattern, 1 appends a
//   pattern byte, 2 feeds a text byte, 3 ends the text. Only an end transaction
//   gives a result on out_chan: match and pattern_overflow.
//   cfg_chan writes case_insensitive; it is always ready. Write it only while idle.
// Timing:
//   A row of MAX_PATTERN cells each holds one pattern byte and its active bit;
//   a text byte updates all cells at once, star runs closing through the row in
//   the same cycle. One item per cycle, unless the Stall case below holds.
//   The result of an end transaction is valid the cycle after it is accepted.
// Stall:
//   The result sits in an output register; in_chan.ready drops only while that
//   register is full and out_chan.ready is low.
// Reset:
//   rst_n (synchronous) empties the pattern, drops any text in progress, clears the
//   overflow flag and the output register, and sets case_insensitive to 1.
//   No clearing pass is needed; the block is ready in the cycle after reset.
module wildcard_glob_matcher
  import gwm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input logic clk,
  input logic rst_n,
  gwm_in_if.sink    in_chan,
  gwm_out_if.source out_chan,
  gwm_cfg_if.sink   cfg_chan
);

  gwm_ctl_t                 ctl;
  gwm_link_t                link [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]   valid_vec;
  logic [MAX_PATTERN-1:0]   hit_vec;
  logic                     fold_r;
  logic                     started_r;
  logic                     started_nxt;
  logic                     ovf_r;
  logic                     ovf_nxt;
  logic                     end_active_r;
  logic                     cur_end;
  logic                     nxt_end;
  logic                     hit_all;
  logic                     out_valid_r;
  logic                     out_match_r;
  logic                     out_ovf_r;
  logic                     accept;

  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign accept         = in_chan.valid && in_chan.ready;

  always_comb begin
    ctl.take       = accept;
    ctl.func       = gwm_func_t'(in_chan.func);
    ctl.byte_value = in_chan.byte_value;
    ctl.fold       = fold_r;
    ctl.started    = started_r;
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    gwm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .seed       ((i == 0) ? 1'b1 : 1'b0),
      .prev_valid ((i == 0) ? 1'b1 : valid_vec[(i == 0) ? 0 : i-1]),
      .link_in    ((i == 0) ? gwm_link_t'('0) : link[(i == 0) ? 0 : i-1]),
      .link_out   (link[i]),
      .valid_out  (valid_vec[i]),
      .hit        (hit_vec[i])
    );
  end

  // position past the last cell: reached only when the pattern is full
  always_comb begin
    cur_end = (started_r & end_active_r) | link[MAX_PATTERN-1].cur_close;
    nxt_end = link[MAX_PATTERN-1].advance | link[MAX_PATTERN-1].next_close;
    hit_all = (|hit_vec) | (cur_end & valid_vec[MAX_PATTERN-1]);
  end

  always_comb begin
    started_nxt = started_r;
    ovf_nxt     = ovf_r;
    if (accept) begin
      case (ctl.func)
        FN_CLEAR: begin
          started_nxt = 1'b0;
          ovf_nxt     = 1'b0;
        end
        FN_APPEND: begin
          started_nxt = 1'b0;
          if (valid_vec[MAX_PATTERN-1]) ovf_nxt = 1'b1;
        end
        FN_TEXT:  started_nxt = 1'b1;
        default:  started_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r       <= 1'b1;
      started_r    <= 1'b0;
      ovf_r        <= 1'b0;
      end_active_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      started_r <= started_nxt;
      ovf_r     <= ovf_nxt;
      if (cfg_chan.valid && cfg_chan.ready) fold_r <= cfg_chan.case_insensitive;
      if (accept && ctl.func == FN_TEXT) end_active_r <= nxt_end;
      if (accept && ctl.func == FN_END) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ctl.func == FN_END) begin
      out_match_r <= hit_all & !ovf_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.match            = out_match_r;
  assign out_chan.pattern_overflow = out_ovf_r;

`ifndef SYNTHESIS
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.func == FN_END) |=> out_chan.valid)
    else $error("end transaction produced no result");

  a_overflow_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.pattern_overflow) |-> !out_chan.match)
    else $error("match reported with pattern overflow");

  a_fill_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, valid_vec} + {{MAX_PATTERN{1'b0}}, 1'b1}))
    else $error("pattern fill bits are not contiguous");

  a_overflow_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(valid_vec[MAX_PATTERN-1]))
    else $error("overflow set with pattern not full");
`endif

endmodule
